>>> design/kmc_pkg.sv
// Shared types, constants and helpers for the k-mer histogram counter.
package kmc_pkg;

    localparam int K_MAX_DEF      = 8;
    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SEEN_W         = 4;
    localparam int KLEN_W         = 4;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd3;

    // Input kind codes
    localparam logic [1:0] KIND_BASE = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_NEW  = 2'd2;

    // ASCII base letters
    localparam logic [7:0] ASCII_A = 8'd65;
    localparam logic [7:0] ASCII_C = 8'd67;
    localparam logic [7:0] ASCII_G = 8'd71;
    localparam logic [7:0] ASCII_T = 8'd84;

    localparam logic [2:0] CODE_BAD = 3'd4;

    // Work handed from the front end to the store side
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_BAD   = 2'd1,
        OP_COUNT = 2'd2,
        OP_READ  = 2'd3
    } kmc_op_t;

    localparam int OP_W = 2;

    // 0..3 for A, C, G, T; CODE_BAD for any other byte
    function automatic logic [2:0] base_code(input logic [7:0] letter);
        logic [2:0] code;
        case (letter)
            ASCII_A: code = 3'd0;
            ASCII_C: code = 3'd1;
            ASCII_G: code = 3'd2;
            ASCII_T: code = 3'd3;
            default: code = CODE_BAD;
        endcase
        return code;
    endfunction

endpackage

>>> design/kmc_ram.sv
// Generic simple dual-port RAM, registered read, read returns old data on collision.
module kmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/kmc_front.sv
// Front end: takes input transfers, decodes bases, slides the k-mer window.
module kmc_front
    import kmc_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF,
    parameter int IDX_W = 2 * K_MAX
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KLEN_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        letter,
    input  logic [15:0]       query_index,
    input  logic              clearing,
    input  logic              q_ready,
    output logic              q_push,
    output kmc_op_t           q_op,
    output logic [IDX_W-1:0]  q_idx
);

    logic [KLEN_W-1:0] kmer_length_reg;
    logic [IDX_W-1:0]  window_reg, window_next;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic [KLEN_W-1:0] k_eff;
    logic [2:0]        code;
    logic [IDX_W-1:0]  kmask;
    logic [IDX_W-1:0]  shifted;
    logic [IDX_W+15:0] query_ext;
    logic              accept;

    assign in_ready = !clearing && q_ready;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    always_comb
    begin
        if (kmer_length_reg == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (kmer_length_reg > KLEN_W'(K_MAX))
        begin
            k_eff = KLEN_W'(K_MAX);
        end
        else
        begin
            k_eff = kmer_length_reg;
        end
    end

    assign code      = base_code(letter);
    assign kmask     = ~({IDX_W{1'b1}} << {k_eff, 1'b0});
    assign shifted   = (window_reg << 2) | IDX_W'(code[1:0]);
    assign seen_inc  = (seen_reg < SEEN_W'(K_MAX)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign query_ext = {{IDX_W{1'b0}}, query_index};

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        q_op        = OP_NONE;
        q_idx       = '0;
        case (kind)
            KIND_BASE:
            begin
                if (code == CODE_BAD)
                begin
                    q_op = OP_BAD;
                end
                else
                begin
                    window_next = shifted;
                    seen_next   = seen_inc;
                    if (seen_inc >= SEEN_W'(k_eff))
                    begin
                        q_op  = OP_COUNT;
                        q_idx = shifted & kmask;
                    end
                end
            end
            KIND_READ:
            begin
                q_op  = OP_READ;
                q_idx = query_ext[IDX_W-1:0];
            end
            KIND_NEW:
            begin
                window_next = '0;
                seen_next   = '0;
            end
            default:
            begin
                q_op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KLEN_RESET;
            window_reg      <= '0;
            seen_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                kmer_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

>>> design/kmc_queue.sv
// Short register queue between the front end and the store side.
module kmc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign ready = (fill_reg != CNT_W'(DEPTH));
    assign valid = (fill_reg != '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> design/kmc_back.sv
// Store side: count RAM read-modify-write, clearing sweep and result register.
module kmc_back
    import kmc_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int IDX_W      = 2 * K_MAX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  kmc_op_t               q_op,
    input  logic [IDX_W-1:0]      q_idx,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COUNT_BITS-1:0] out_count,
    output logic [IDX_W-1:0]      out_idx,
    output logic                  out_counted,
    output logic                  out_bad
);

    localparam int DEPTH = 1 << IDX_W;

    logic                  clearing_reg;
    logic [IDX_W-1:0]      clr_addr_reg;

    logic                  s2_valid_reg;
    kmc_op_t               s2_op_reg;
    logic [IDX_W-1:0]      s2_idx_reg;
    logic                  s2_adv;

    logic                  fwd_valid_reg;
    logic [IDX_W-1:0]      fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_counted_reg;
    logic                  out_bad_reg;

    logic                  rd_en;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign clearing = clearing_reg;
    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop    = q_valid && !clearing_reg && (!s2_valid_reg || s2_adv);
    assign rd_en    = q_pop && (q_op == OP_COUNT || q_op == OP_READ);

    // Bypass the write that landed on the same edge as this entry's read
    assign cur_count = (fwd_valid_reg && fwd_addr_reg == s2_idx_reg) ? fwd_data_reg : rd_data;
    assign inc_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                         : cur_count + COUNT_BITS'(1);

    assign wr_en   = clearing_reg || (s2_adv && s2_op_reg == OP_COUNT);
    assign wr_addr = clearing_reg ? clr_addr_reg : s2_idx_reg;
    assign wr_data = clearing_reg ? '0 : inc_count;

    kmc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (q_idx),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == {IDX_W{1'b1}})
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (q_pop)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv && s2_op_reg == OP_COUNT)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_op_reg  <= q_op;
            s2_idx_reg <= q_idx;
        end
        if (s2_adv && s2_op_reg == OP_COUNT)
        begin
            fwd_addr_reg <= s2_idx_reg;
            fwd_data_reg <= inc_count;
        end
        if (s2_adv)
        begin
            case (s2_op_reg)
                OP_COUNT:
                begin
                    out_count_reg   <= inc_count;
                    out_idx_reg     <= s2_idx_reg;
                    out_counted_reg <= 1'b1;
                    out_bad_reg     <= 1'b0;
                end
                OP_READ:
                begin
                    out_count_reg   <= cur_count;
                    out_idx_reg     <= s2_idx_reg;
                    out_counted_reg <= 1'b0;
                    out_bad_reg     <= 1'b0;
                end
                OP_BAD:
                begin
                    out_count_reg   <= '0;
                    out_idx_reg     <= '0;
                    out_counted_reg <= 1'b0;
                    out_bad_reg     <= 1'b1;
                end
                default:
                begin
                    out_count_reg   <= '0;
                    out_idx_reg     <= '0;
                    out_counted_reg <= 1'b0;
                    out_bad_reg     <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_count   = out_count_reg;
    assign out_idx     = out_idx_reg;
    assign out_counted = out_counted_reg;
    assign out_bad     = out_bad_reg;

endmodule

>>> design/kmer_histogram_counter.sv
// Top level of the k-mer histogram counter: front end, queue and count store.
//
//  channel  | direction | tdata (low bit up)                  | tuser (low bit up)
//  ---------+-----------+-------------------------------------+--------------------------
//  s_axis   | in        | letter[7:0], query_index[15:0]      | kind[1:0]
//  m_axis   | out       | count_value[31:0], kmer_index[15:0] | counted, bad_letter
//  cfg      | in        | cfg_wdata = kmer_length[3:0]        | -
//
// Cycles: one transfer per cycle in and out when m_tready stays high. m_tvalid
//   rises after the input transfer passes the queue entry (written on the transfer
//   edge), the count RAM read, then increment, write-back and the result register.
//   The count RAM takes one read and one write a cycle; a same-index increment on
//   back-to-back bases is bypassed from the last write.
// Reset: rst_n clears control state, then a sweep zeroes the count store, one
//   entry a cycle, over all 4^K_MAX entries (65536 at K_MAX = 8); s_tready stays
//   low during the sweep. Configuration writes are taken at any time.
// Stalls: the queue lets the input side keep accepting while m_tready is low
//   until it fills; a held result stays stable on m_axis until transferred.
module kmer_histogram_counter
    import kmc_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration: kmer_length
    input  logic              cfg_we,
    input  logic [KLEN_W-1:0] cfg_wdata,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // letter[7:0], query_index[23:8]
    input  logic [1:0]        s_tuser,   // kind[1:0]
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // count_value[31:0], kmer_index[47:32]
    output logic [1:0]        m_tuser    // counted[0], bad_letter[1]
);

    localparam int IDX_W = 2 * K_MAX;
    localparam int ENT_W = OP_W + IDX_W;

    logic                  clearing;
    logic                  q_push, q_ready, q_pop, q_valid;
    kmc_op_t               push_op;
    logic [IDX_W-1:0]      push_idx;
    logic [ENT_W-1:0]      q_head;
    kmc_op_t               head_op;
    logic [IDX_W-1:0]      head_idx;

    logic [COUNT_BITS-1:0] out_count;
    logic [IDX_W-1:0]      out_idx;
    logic                  out_counted, out_bad;
    logic [COUNT_BITS+31:0] count_ext;
    logic [IDX_W+15:0]      idx_ext;

    // Classify each transfer and keep the sliding window
    kmc_front #(
        .K_MAX (K_MAX),
        .IDX_W (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .letter      (s_tdata[7:0]),
        .query_index (s_tdata[23:8]),
        .clearing    (clearing),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_op        (push_op),
        .q_idx       (push_idx)
    );

    // Decouple the two sides
    kmc_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_op, push_idx}),
        .ready     (q_ready),
        .pop       (q_pop),
        .head      (q_head),
        .valid     (q_valid)
    );

    assign head_op  = kmc_op_t'(q_head[ENT_W-1:IDX_W]);
    assign head_idx = q_head[IDX_W-1:0];

    // Count store side
    kmc_back #(
        .K_MAX      (K_MAX),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_op        (head_op),
        .q_idx       (head_idx),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_count   (out_count),
        .out_idx     (out_idx),
        .out_counted (out_counted),
        .out_bad     (out_bad)
    );

    // Fit the store's widths to the fixed result fields
    assign count_ext = {32'b0, out_count};
    assign idx_ext   = {16'b0, out_idx};
    assign m_tdata   = {idx_ext[15:0], count_ext[31:0]};
    assign m_tuser   = {out_bad, out_counted};

endmodule

>>> design/kmc_checker.sv
// Port-level checker for the k-mer histogram counter, bound to the top level.
module kmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic [7:0] pending_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    // Every result belongs to an input transfer not yet answered
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result shown with no outstanding input transfer");

    // A bad letter result carries nothing else
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 48'd0 && !m_tuser[0]))
        else $error("bad letter result with other fields set");

    // Input is not ready when rst_n is first seen high, as the clearing sweep starts
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input accepted right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind kmer_histogram_counter kmc_checker u_kmc_checker (.*);

>>> tb/kmer_stream_checker.sv
// Checker for the k-mer histogram counter: predicts each result and compares it on m_axis.
module kmer_stream_checker
    import kmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KLEN_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,   // letter[7:0], query_index[23:8]
    input  logic [1:0]        s_tuser,   // kind[1:0]
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,   // count_value[31:0], kmer_index[47:32]
    input  logic [1:0]        m_tuser,   // counted[0], bad_letter[1]
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [31:0] count_value;
        logic [15:0] kmer_index;
        logic        counted;
        logic        bad_letter;
    } kmer_result_t;

    kmer_result_t      awaited_results[$];
    logic [31:0]       kmer_counts [0:(1 << (2 * K_MAX_DEF)) - 1];
    logic [15:0]       window;
    logic [SEEN_W-1:0] bases_in_seq;
    logic [KLEN_W-1:0] klen;
    kmer_result_t      got_result;
    kmer_result_t      want_result;

    task automatic report_mismatch(input string msg);
        $display("[%0t] kmer check failed: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    // Advance the window and the count table for one transfer; return its result.
    function automatic kmer_result_t predict_item(input logic [1:0] kind,
                                                  input logic [7:0] letter,
                                                  input logic [15:0] query);
        kmer_result_t res;
        logic [1:0]   code;
        logic         is_base;
        int           k;
        logic [15:0]  idx;
        res = '0;
        case (kind)
            KIND_BASE:
            begin
                is_base = 1'b1;
                code    = 2'd0;
                case (letter)
                    ASCII_A: code = 2'd0;
                    ASCII_C: code = 2'd1;
                    ASCII_G: code = 2'd2;
                    ASCII_T: code = 2'd3;
                    default: is_base = 1'b0;
                endcase
                if (!is_base)
                begin
                    res.bad_letter = 1'b1;
                end
                else
                begin
                    k = (klen == 0) ? 1 : (klen > K_MAX_DEF) ? K_MAX_DEF : int'(klen);
                    window = {window[13:0], code};
                    if (bases_in_seq < K_MAX_DEF)
                        bases_in_seq++;
                    if (bases_in_seq >= k)
                    begin
                        idx = window & 16'((1 << (2 * k)) - 1);
                        if (kmer_counts[idx] != '1)
                            kmer_counts[idx]++;
                        res.count_value = kmer_counts[idx];
                        res.kmer_index  = idx;
                        res.counted     = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                res.count_value = kmer_counts[query];
                res.kmer_index  = query;
            end
            KIND_NEW:
            begin
                window       = '0;
                bases_in_seq = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (kmer_counts[i])
                kmer_counts[i] = '0;
            window       = '0;
            bases_in_seq = '0;
            klen         = KLEN_RESET;
            fail_count   = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            // a result never leaves in the cycle of its own transfer, so pop before push
            if (m_tvalid && m_tready)
            begin
                got_result = {m_tdata[31:0], m_tdata[47:32], m_tuser[0], m_tuser[1]};
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0h with nothing outstanding",
                                              got_result));
                end
                else
                begin
                    want_result = awaited_results.pop_front();
                    compare_field("count_value", got_result.count_value,
                                  want_result.count_value);
                    compare_field("kmer_index", got_result.kmer_index,
                                  want_result.kmer_index);
                    compare_field("counted", got_result.counted, want_result.counted);
                    compare_field("bad_letter", got_result.bad_letter,
                                  want_result.bad_letter);
                end
            end
            if (cfg_we)
                klen = cfg_wdata;
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_item(s_tuser, s_tdata[7:0],
                                                       s_tdata[23:8]));
            pending <= awaited_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the k-mer histogram counter: clock, reset, stimulus and verdict.
module tb_top;
    import kmc_pkg::*;

    // kind code the block treats as a no-op
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 10;

    logic              clk       = 1'b0;
    logic              rst_n;
    logic              cfg_we    = 1'b0;
    logic [KLEN_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;    // letter[7:0], query_index[23:8]
    logic [1:0]        s_tuser   = '0;    // kind[1:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;           // count_value[31:0], kmer_index[47:32]
    logic [1:0]        m_tuser;           // counted[0], bad_letter[1]

    int fail_count;
    int pending;

    // when set, the matching side never idles, giving full-rate stretches
    bit steady_tx = 1'b0;
    bit steady_rx = 1'b0;
    int rx_hold   = 0;
    int rx_next;

    logic [7:0] base_letters [4] = '{ASCII_A, ASCII_C, ASCII_G, ASCII_T};

    // k settings for the random phases: extremes and the out-of-range codes
    logic [KLEN_W-1:0] phase_klen [NUM_PHASES] = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd2,
                                                   4'd0, 4'd6, 4'd3, 4'd5, 4'd7};

    kmer_histogram_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    kmer_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: after each result transfer, drop tready for a randomly drawn hold, which may be zero.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rx_next = steady_rx ? 0 : $urandom_range(0, 11);
        else if (rx_hold > 0)
            rx_next = rx_hold - 1;
        else
            rx_next = 0;
        rx_hold  <= rx_next;
        m_tready <= (rx_next == 0);
    end

    // Send one item: idle for a drawn gap, then hold it until the transfer.
    // tvalid stays high on return so that a zero-gap item follows back to back.
    task automatic send_transfer(input logic [1:0] kind, input logic [7:0] letter,
                                 input logic [15:0] query);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= kind;
        s_tdata  <= {query, letter};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Hold off the sender until every outstanding result is back, then let
    // the pipeline settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write kmer_length while the block is idle.
    task automatic write_kmer_length(input logic [KLEN_W-1:0] value);
        wait_for_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Draw one item: mostly bases, with reads, restarts, bad letters and the
    // spare kind mixed in; unused fields carry random bits.
    task automatic send_random_item(input int k_eff);
        int          pick;
        logic [15:0] query;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            send_transfer(KIND_BASE, base_letters[$urandom_range(0, 3)], 16'($urandom));
        end
        else if (pick < 80)
        begin
            // half the reads stay within the live k-mer range to hit nonzero counts
            if ($urandom_range(0, 1) == 1)
                query = 16'($urandom_range(0, (1 << (2 * k_eff)) - 1));
            else
                query = 16'($urandom);
            send_transfer(KIND_READ, 8'($urandom), query);
        end
        else if (pick < 85)
        begin
            send_transfer(KIND_NEW, 8'($urandom), 16'($urandom));
        end
        else if (pick < 93)
        begin
            send_transfer(KIND_BASE, 8'($urandom_range(0, 255)), 16'($urandom));
        end
        else
        begin
            send_transfer(KIND_SPARE, 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        int k_eff;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: length 0 acts as 1, so every good base counts on its own.
        write_kmer_length(4'd0);
        send_transfer(KIND_BASE, ASCII_A, 16'h0000);
        send_transfer(KIND_BASE, ASCII_C, 16'hFFFF);
        send_transfer(KIND_BASE, ASCII_G, 16'h0000);
        send_transfer(KIND_BASE, ASCII_T, 16'hFFFF);
        // bad letters: extremes and a lower-case base
        send_transfer(KIND_BASE, 8'h00, 16'h0000);
        send_transfer(KIND_BASE, 8'hFF, 16'hFFFF);
        send_transfer(KIND_BASE, 8'h61, 16'h0000);
        send_transfer(KIND_BASE, ASCII_A, 16'h0000);
        send_transfer(KIND_READ, 8'hFF, 16'h0000);
        send_transfer(KIND_READ, 8'h00, 16'hFFFF);
        send_transfer(KIND_SPARE, ASCII_A, 16'hFFFF);
        send_transfer(KIND_NEW, 8'hFF, 16'hFFFF);

        // Length above the maximum acts as the maximum: nine T's fill the window.
        write_kmer_length(4'd15);
        repeat (9) send_transfer(KIND_BASE, ASCII_T, 16'h0000);
        send_transfer(KIND_READ, 8'h00, 16'hFFFF);

        // Shorten the length mid-sequence: the window carries over.
        write_kmer_length(4'd2);
        send_transfer(KIND_BASE, ASCII_C, 16'h0000);
        send_transfer(KIND_READ, 8'h00, 16'h000D);
        // after a restart one base is too few for a 2-mer
        send_transfer(KIND_NEW, 8'h00, 16'h0000);
        send_transfer(KIND_BASE, ASCII_G, 16'h0000);

        // Random phases, each under its own length and idle pattern; the sender
        // drains all results before every length change.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_kmer_length(phase_klen[p]);
            k_eff = (phase_klen[p] == 0) ? 1 :
                    (phase_klen[p] > K_MAX_DEF) ? K_MAX_DEF : int'(phase_klen[p]);
            steady_tx = ($urandom_range(0, 3) == 0);
            steady_rx = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item(k_eff);
        end

        wait_for_results();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Bound the run: the store sweep after reset plus a fully stalled run is
    // well under a fifth of this.
    initial
    begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
design/kmc_pkg.sv
design/kmc_ram.sv
design/kmc_front.sv
design/kmc_queue.sv
design/kmc_back.sv
design/kmer_histogram_counter.sv
design/kmc_checker.sv
tb/kmer_stream_checker.sv
tb/tb_top.sv
